/* sv/pedestal_subtract_with_channel_stats_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pedestal subtraction block.
// ----------------------------------------------------------------------------
`ifndef PEDESTAL_SUBTRACT_WITH_CHANNEL_STATS_DEFINES_SVH
`define PEDESTAL_SUBTRACT_WITH_CHANNEL_STATS_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define PSS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define PSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pss_pkg.sv */
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants of the pedestal subtraction block.
// ----------------------------------------------------------------------------
package pss_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_SUB  = 2'd1,
        CMD_ADD  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // Register indexes on the configuration port.
    localparam logic REG_HITBUS_MASK = 1'b0;
    localparam logic REG_DATA_MASK   = 1'b1;

    localparam logic [15:0] HITBUS_MASK_RST = 16'h1000;
    localparam logic [15:0] DATA_MASK_RST   = 16'h0FFF;

    localparam logic [8:0]         COUNT_CAP = 9'd256;
    localparam logic signed [15:0] MAX_INIT  = -16'sd4095;
    localparam logic signed [15:0] MIN_INIT  = 16'sd4095;

    // Running statistics of the channel being collected.
    typedef struct packed {
        logic signed [15:0] max;
        logic signed [15:0] min;
        logic [8:0]         count;
        logic signed [23:0] sum;
        logic [39:0]        sum_sq;
    } run_t;

    localparam run_t RUN_INIT = '{
        max:    MAX_INIT,
        min:    MIN_INIT,
        count:  9'd0,
        sum:    24'sd0,
        sum_sq: 40'd0
    };

endpackage

/* sv/pedestal_subtract_with_channel_stats.sv */
// ----------------------------------------------------------------------------
// pedestal_subtract_with_channel_stats
// Pedestal table, per-sample subtraction and per-channel statistics.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                       Transfer when
//  -------   -------------------------------------------   -------------------
//  config    psel penable pwrite paddr pwdata prdata       psel&penable&pwrite
//  input     in_valid in_ready, cmd .. subbed_value        in_valid & in_ready
//  output    out_valid out_ready, sub_value .. chan_rms    out_valid & out_ready
//
//  A load is written at its input transfer. Subtract and add pass through
//  accept, table read and result. A subtract of a channel's last sample
//  goes on to a multiply step, a difference step, 32 square root steps and
//  two 32-step divisions, which share one restoring divider.
//  Reset is asynchronous; the pedestal table is not cleared and needs no
//  clearing pass. A new input transfer is taken while the previous result
//  still waits in the output register; a stalled output holds the next
//  result in the block until the output register frees.
//
module pedestal_subtract_with_channel_stats #(
    parameter int NUM_BOARDS          = 8,
    parameter int CHIPS_PER_BOARD     = 4,
    parameter int CHANNELS_PER_BOARD  = 8,
    parameter int SAMPLES_PER_CHANNEL = 256
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [2:0]         board,
    input  logic [1:0]         chip,
    input  logic [2:0]         channel,
    input  logic [7:0]         sample_index,
    input  logic [15:0]        raw_word,
    input  logic [11:0]        pedestal_value,
    input  logic signed [15:0] subbed_value,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sub_value,
    output logic [15:0]        restored_word,
    output logic               stats_valid,
    output logic signed [15:0] chan_max,
    output logic signed [15:0] chan_min,
    output logic [8:0]         valid_count,
    output logic signed [23:0] chan_mean,
    output logic [22:0]        chan_rms
);

    `include "pedestal_subtract_with_channel_stats_defines.svh"

    localparam int TABLE_DEPTH =
        NUM_BOARDS * CHIPS_PER_BOARD * CHANNELS_PER_BOARD * SAMPLES_PER_CHANNEL;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_MUL,
        ST_VAR,
        ST_SQRT,
        ST_DIV,
        ST_DELIVER
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers. The port has no wait states.
    // ------------------------------------------------------------------
    logic [15:0] hitbus_mask_reg;
    logic [15:0] data_mask_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hitbus_mask_reg <= pss_pkg::HITBUS_MASK_RST;
            data_mask_reg   <= pss_pkg::DATA_MASK_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == pss_pkg::REG_HITBUS_MASK)
            begin
                hitbus_mask_reg <= pwdata[15:0];
            end
            else
            begin
                data_mask_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == pss_pkg::REG_DATA_MASK) ? {16'd0, data_mask_reg}
                                                         : {16'd0, hitbus_mask_reg};

    // ------------------------------------------------------------------
    // Pedestal table address. An address outside the configured geometry
    // drops a load and reads as a zero pedestal.
    // ------------------------------------------------------------------
    state_t      state_reg;
    logic        in_xfer;
    logic        addr_ok;
    logic [31:0] addr_full;
    logic [ADDR_W-1:0] tbl_addr;
    logic [11:0] ped_rd;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;

    assign addr_ok = (32'(board) < NUM_BOARDS) && (32'(chip) < CHIPS_PER_BOARD) &&
                     (32'(channel) < CHANNELS_PER_BOARD) &&
                     (32'(sample_index) < SAMPLES_PER_CHANNEL);
    assign addr_full = 32'(((32'(board) * CHIPS_PER_BOARD + 32'(chip))
                           * CHANNELS_PER_BOARD + 32'(channel))
                           * SAMPLES_PER_CHANNEL + 32'(sample_index));
    assign tbl_addr  = addr_full[ADDR_W-1:0];

    pss_ram #(
        .WIDTH (12),
        .DEPTH (TABLE_DEPTH)
    ) u_ped_ram (
        .clk     (clk),
        .wr_en   (in_xfer && (cmd == pss_pkg::CMD_LOAD) && addr_ok),
        .wr_addr (tbl_addr),
        .wr_data (pedestal_value),
        .rd_en   (in_xfer),
        .rd_addr (tbl_addr),
        .rd_data (ped_rd)
    );

    // ------------------------------------------------------------------
    // Item registers captured at the input transfer.
    // ------------------------------------------------------------------
    logic [1:0]         cmd_reg;
    logic               addr_ok_reg;
    logic               chan_zero_reg;
    logic               samp_first_reg;
    logic               samp_last_reg;
    logic [15:0]        raw_reg;
    logic signed [15:0] subbed_reg;

    // ------------------------------------------------------------------
    // Sample path, evaluated in the cycle the table data arrives.
    // ------------------------------------------------------------------
    pss_pkg::run_t      run_reg;
    pss_pkg::run_t      run_base;
    pss_pkg::run_t      run_next;
    logic [11:0]        ped;
    logic               hit;
    logic [15:0]        masked;
    logic signed [16:0] diff;
    logic signed [15:0] samp_val;
    logic signed [31:0] samp_sq;
    logic               take;
    logic [15:0]        restored;

    assign ped      = addr_ok_reg ? ped_rd : 12'd0;
    assign hit      = (raw_reg & hitbus_mask_reg) != 16'd0;
    assign masked   = raw_reg & data_mask_reg;
    assign diff     = $signed({2'b00, masked[15:1]}) - $signed({5'd0, ped});
    assign samp_val = (hit || (chan_zero_reg && samp_first_reg)) ? 16'sd0 : diff[15:0];
    assign samp_sq  = samp_val * samp_val;
    assign restored = subbed_reg + {4'd0, ped};

    // A channel starts over at its first sample.
    assign run_base = samp_first_reg ? pss_pkg::RUN_INIT : run_reg;
    assign take     = !hit && (run_base.count < pss_pkg::COUNT_CAP);

    always_comb
    begin
        run_next = run_base;
        if (take)
        begin
            if (samp_val > run_base.max)
            begin
                run_next.max = samp_val;
            end
            if (samp_val < run_base.min)
            begin
                run_next.min = samp_val;
            end
            run_next.sum    = run_base.sum + {{8{samp_val[15]}}, samp_val};
            run_next.sum_sq = run_base.sum_sq + {8'd0, samp_sq};
            run_next.count  = run_base.count + 9'd1;
        end
    end

    // ------------------------------------------------------------------
    // Channel statistics: snapshot, products, integer square root and a
    // restoring divider shared by the mean and the rms.
    // ------------------------------------------------------------------
    pss_pkg::run_t      st_reg;
    logic [23:0]        abs_sum;
    logic [48:0]        prod_nsq_reg;
    logic [47:0]        prod_ss_reg;
    logic signed [49:0] var_val;
    logic [63:0]        sq_x_reg;
    logic [63:0]        sq_root_reg;
    logic [63:0]        sq_bit_reg;
    logic [63:0]        sq_trial;
    logic [31:0]        dv_q_reg;
    logic [8:0]         dv_rem_reg;
    logic [4:0]         dv_cnt_reg;
    logic               dv_rms_reg;
    logic [9:0]         dv_shift;
    logic               dv_ge;
    logic [9:0]         dv_diff;
    logic [31:0]        dv_q_fin;
    logic [31:0]        mean_mag;

    assign abs_sum  = st_reg.sum[23] ? 24'(-st_reg.sum) : st_reg.sum;
    assign var_val  = $signed({1'b0, prod_nsq_reg}) - $signed({2'b00, prod_ss_reg});
    assign sq_trial = sq_root_reg + sq_bit_reg;
    assign dv_shift = {dv_rem_reg, dv_q_reg[31]};
    assign dv_ge    = dv_shift >= {1'b0, st_reg.count};
    assign dv_diff  = dv_shift - {1'b0, st_reg.count};
    assign dv_q_fin = {dv_q_reg[30:0], dv_ge};
    assign mean_mag = st_reg.sum[23] ? 32'(-dv_q_fin) : dv_q_fin;

    // ------------------------------------------------------------------
    // Result staging and the output register.
    // ------------------------------------------------------------------
    logic signed [15:0] res_sub_reg;
    logic [15:0]        res_restored_reg;
    logic               res_stats_reg;
    logic signed [15:0] res_max_reg;
    logic signed [15:0] res_min_reg;
    logic [8:0]         res_count_reg;
    logic signed [23:0] res_mean_reg;
    logic [22:0]        res_rms_reg;
    logic               out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            run_reg       <= pss_pkg::RUN_INIT;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        cmd_reg        <= cmd;
                        addr_ok_reg    <= addr_ok;
                        chan_zero_reg  <= (channel == 3'd0);
                        samp_first_reg <= (sample_index == 8'd0);
                        samp_last_reg  <= (32'(sample_index) == SAMPLES_PER_CHANNEL - 1);
                        raw_reg        <= raw_word;
                        subbed_reg     <= subbed_value;
                        if (cmd == pss_pkg::CMD_SUB || cmd == pss_pkg::CMD_ADD)
                        begin
                            state_reg <= ST_LOOKUP;
                        end
                    end
                end

                ST_LOOKUP:
                begin
                    res_stats_reg <= 1'b0;
                    res_max_reg   <= 16'sd0;
                    res_min_reg   <= 16'sd0;
                    res_count_reg <= 9'd0;
                    res_mean_reg  <= 24'sd0;
                    res_rms_reg   <= 23'd0;
                    state_reg     <= ST_DELIVER;
                    if (cmd_reg == pss_pkg::CMD_ADD)
                    begin
                        res_sub_reg      <= 16'sd0;
                        res_restored_reg <= restored;
                    end
                    else
                    begin
                        res_sub_reg      <= samp_val;
                        res_restored_reg <= 16'd0;
                        if (samp_last_reg)
                        begin
                            // Close the channel: freeze its statistics and
                            // start the next one from the reset values.
                            st_reg        <= run_next;
                            run_reg       <= pss_pkg::RUN_INIT;
                            res_stats_reg <= 1'b1;
                            res_max_reg   <= run_next.max;
                            res_min_reg   <= run_next.min;
                            res_count_reg <= run_next.count;
                            state_reg     <= ST_MUL;
                        end
                        else
                        begin
                            run_reg <= run_next;
                        end
                    end
                end

                ST_MUL:
                begin
                    prod_nsq_reg <= st_reg.count * st_reg.sum_sq;
                    prod_ss_reg  <= abs_sum * abs_sum;
                    state_reg    <= ST_VAR;
                end

                ST_VAR:
                begin
                    // A variance that is not positive gives a root of zero.
                    sq_x_reg    <= (var_val > 50'sd0) ? {var_val[47:0], 16'd0} : 64'd0;
                    sq_root_reg <= 64'd0;
                    sq_bit_reg  <= 64'd1 << 62;
                    state_reg   <= ST_SQRT;
                end

                ST_SQRT:
                begin
                    if (sq_x_reg >= sq_trial)
                    begin
                        sq_x_reg    <= sq_x_reg - sq_trial;
                        sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_root_reg <= sq_root_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0])
                    begin
                        dv_q_reg   <= {abs_sum, 8'd0};
                        dv_rem_reg <= 9'd0;
                        dv_cnt_reg <= 5'd0;
                        dv_rms_reg <= 1'b0;
                        state_reg  <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    dv_rem_reg <= dv_ge ? dv_diff[8:0] : dv_shift[8:0];
                    dv_q_reg   <= dv_q_fin;
                    dv_cnt_reg <= dv_cnt_reg + 5'd1;
                    if (dv_cnt_reg == 5'd31)
                    begin
                        if (!dv_rms_reg)
                        begin
                            res_mean_reg <= (st_reg.count == 9'd0) ? 24'sd0
                                                                   : mean_mag[23:0];
                            dv_q_reg     <= sq_root_reg[31:0];
                            dv_rem_reg   <= 9'd0;
                            dv_rms_reg   <= 1'b1;
                        end
                        else
                        begin
                            res_rms_reg <= (st_reg.count == 9'd0) ? 23'd0 : dv_q_fin[22:0];
                            state_reg   <= ST_DELIVER;
                        end
                    end
                end

                ST_DELIVER:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        sub_value     <= res_sub_reg;
                        restored_word <= res_restored_reg;
                        stats_valid   <= res_stats_reg;
                        chan_max      <= res_max_reg;
                        chan_min      <= res_min_reg;
                        valid_count   <= res_count_reg;
                        chan_mean     <= res_mean_reg;
                        chan_rms      <= res_rms_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PSS_ASSERT_NEXT(a_busy_after_item,
        in_valid && in_ready && (cmd == pss_pkg::CMD_SUB || cmd == pss_pkg::CMD_ADD),
        !in_ready, "input taken while an item is still in work")
    `PSS_ASSERT_IMPLIES(a_plain_result_no_stats,
        out_valid && !stats_valid,
        chan_max == 16'sd0 && chan_min == 16'sd0 && valid_count == 9'd0 &&
        chan_mean == 24'sd0 && chan_rms == 23'd0,
        "statistics fields set on a result without statistics")
    `PSS_ASSERT_IMPLIES(a_run_count_cap,
        1'b1, run_reg.count <= pss_pkg::COUNT_CAP, "running count passed its cap")
    `PSS_ASSERT_IMPLIES(a_stats_count_cap,
        out_valid && stats_valid, valid_count <= pss_pkg::COUNT_CAP,
        "reported count passed its cap")

endmodule

/* sv/pss_ram.sv */
// ----------------------------------------------------------------------------
// pss_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pss_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* tb/pss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_checker
// Watches the configuration, input and output channels of the pedestal
// subtraction block. It predicts every result from its own copy of the
// pedestal table, the masks and the running channel statistics, and compares
// each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module pss_checker
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,

    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [2:0]         board,
    input  logic [1:0]         chip,
    input  logic [2:0]         channel,
    input  logic [7:0]         sample_index,
    input  logic [15:0]        raw_word,
    input  logic [11:0]        pedestal_value,
    input  logic signed [15:0] subbed_value,

    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] sub_value,
    input  logic [15:0]        restored_word,
    input  logic               stats_valid,
    input  logic signed [15:0] chan_max,
    input  logic signed [15:0] chan_min,
    input  logic [8:0]         valid_count,
    input  logic signed [23:0] chan_mean,
    input  logic [22:0]        chan_rms,

    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [15:0] sub;
        logic [15:0] restored;
        logic        stats;
        logic [15:0] maxv;
        logic [15:0] minv;
        logic [8:0]  count;
        logic [23:0] mean;
        logic [22:0] rms;
    } sample_result_t;

    sample_result_t    result_q[$];
    logic [11:0]       ped_mem [0:65535];
    logic [15:0]       hitbus_cfg;
    logic [15:0]       data_cfg;
    int                acc_max;
    int                acc_min;
    longint            acc_sum;
    longint unsigned   acc_sq;
    int                acc_count;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    task automatic clear_channel();
        acc_max = -4095;
        acc_min = 4095;
        acc_sum = 0;
        acc_sq = 0;
        acc_count = 0;
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Works out the result of one accepted transfer; loads queue none.
    task automatic predict_transfer();
        sample_result_t  res;
        logic [15:0]     addr;
        int              smp;
        longint          n;
        longint          var_n;
        longint          mean;
        longint unsigned rms;
        addr = {board, chip, channel, sample_index};
        res = '0;
        case (pss_pkg::cmd_t'(cmd))
            pss_pkg::CMD_LOAD: ped_mem[addr] = pedestal_value;
            pss_pkg::CMD_ADD:
            begin
                res.restored = subbed_value + {4'd0, ped_mem[addr]};
                result_q.push_back(res);
            end
            pss_pkg::CMD_SUB:
            begin
                smp = 0;
                if (sample_index == 0)
                    clear_channel();
                if ((raw_word & hitbus_cfg) == 0)
                begin
                    smp = int'((raw_word & data_cfg) >> 1) - int'(ped_mem[addr]);
                    // The first sample of channel zero on every board reads as zero.
                    if (channel == 0 && sample_index == 0)
                        smp = 0;
                    if (acc_count < 256)
                    begin
                        if (smp > acc_max) acc_max = smp;
                        if (smp < acc_min) acc_min = smp;
                        acc_sum += smp;
                        acc_sq += longint'(smp) * longint'(smp);
                        acc_count++;
                    end
                end
                res.sub = smp[15:0];
                if (sample_index == 8'd255)
                begin
                    mean = 0;
                    rms = 0;
                    if (acc_count != 0)
                    begin
                        n = acc_count;
                        mean = (acc_sum * 256) / n;
                        var_n = n * longint'(acc_sq) - acc_sum * acc_sum;
                        if (var_n > 0)
                            rms = int_sqrt(longint'(var_n) * 65536) / n;
                    end
                    res.stats = 1'b1;
                    res.maxv = acc_max[15:0];
                    res.minv = acc_min[15:0];
                    res.count = acc_count[8:0];
                    res.mean = mean[23:0];
                    res.rms = rms[22:0];
                    clear_channel();
                end
                result_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sample_result_t want;
        if (!rst_n)
        begin
            result_q.delete();
            hitbus_cfg = pss_pkg::HITBUS_MASK_RST;
            data_cfg = pss_pkg::DATA_MASK_RST;
            clear_channel();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {pss_pkg::REG_HITBUS_MASK, 2'b00})
                    hitbus_cfg = pwdata[15:0];
                else if (paddr == {pss_pkg::REG_DATA_MASK, 2'b00})
                    data_cfg = pwdata[15:0];
            end
            // Results leave before the new transfer is predicted; they always
            // belong to older transfers.
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t unexpected output transfer: expected none, actual sub %0d",
                             $time, sub_value);
                    errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("sub_value", signed'(want.sub), sub_value);
                    check_field("restored_word", want.restored, restored_word);
                    check_field("stats_valid", want.stats, stats_valid);
                    check_field("chan_max", signed'(want.maxv), chan_max);
                    check_field("chan_min", signed'(want.minv), chan_min);
                    check_field("valid_count", want.count, valid_count);
                    check_field("chan_mean", signed'(want.mean), chan_mean);
                    check_field("chan_rms", want.rms, chan_rms);
                end
            end
            if (in_valid && in_ready)
                predict_transfer();
            pending = result_q.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pedestal loads, subtractions and restores into the block through
// several mask settings, with random gaps on both channels, a long output
// stall and a sender pause. The checker beside the block judges each result.
// ----------------------------------------------------------------------------
module testbench;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         cmd;
    logic [2:0]         board;
    logic [1:0]         chip;
    logic [2:0]         channel;
    logic [7:0]         sample_index;
    logic [15:0]        raw_word;
    logic [11:0]        pedestal_value;
    logic signed [15:0] subbed_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] sub_value;
    logic [15:0]        restored_word;
    logic               stats_valid;
    logic signed [15:0] chan_max;
    logic signed [15:0] chan_min;
    logic [8:0]         valid_count;
    logic signed [23:0] chan_mean;
    logic [22:0]        chan_rms;

    int errors;
    int pending;

    // Stimulus bookkeeping. Only pedestal entries that have been loaded are
    // ever subtracted or restored, so the table's undefined contents never matter.
    bit          loaded [0:65535];
    logic [15:0] loaded_list[$];
    logic [15:0] hitbus_now;
    int          items;
    bit          gaps_on;
    bit          stall_request;
    int          quiet_cycles;

    localparam int PHASE_ITEMS = 270;
    localparam int STALL_CYCLES = 400;
    localparam int SETTLE_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 4000;

    pedestal_subtract_with_channel_stats dut (.*);

    pss_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // The receiver stalls at random, or holds off for a long stretch when
    // the stimulus asks for it so that the block backs up into its input.
    always @(posedge clk)
    begin
        if (stall_request)
        begin
            out_ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clk);
            stall_request = 1'b0;
        end
        else
        begin
            out_ready <= !(gaps_on && $urandom_range(99) < 31);
        end
    end

    // The watchdog ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // One input transfer, with random idle cycles ahead of it while gaps are on.
    task automatic send(pss_pkg::cmd_t op, logic [2:0] b, logic [1:0] c, logic [2:0] ch,
                        logic [7:0] s, logic [15:0] raw, logic [11:0] ped,
                        logic [15:0] subv);
        if (gaps_on && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 31);
        end
        in_valid <= 1'b1;
        cmd <= op;
        board <= b;
        chip <= c;
        channel <= ch;
        sample_index <= s;
        raw_word <= raw;
        pedestal_value <= ped;
        subbed_value <= subv;
        do
            @(posedge clk);
        while (!in_ready);
        if (op != pss_pkg::CMD_NONE)
            items++;
    endtask

    function automatic logic [11:0] pick_pedestal();
        case ($urandom_range(9))
            0: return 12'd0;
            1: return 12'hFFF;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    function automatic logic [15:0] pick_raw();
        logic [15:0] raw;
        raw = 16'($urandom_range(65535));
        case ($urandom_range(19))
            0: raw = 16'h0000;
            1: raw = 16'hFFFF;
            default: ;
        endcase
        // Most samples are kept clear of the hitbus bits.
        if ($urandom_range(3) != 0)
            raw = raw & ~hitbus_now;
        return raw;
    endfunction

    task automatic load_entry(logic [15:0] addr);
        send(pss_pkg::CMD_LOAD, addr[15:13], addr[12:11], addr[10:8], addr[7:0],
             16'($urandom), pick_pedestal(), 16'($urandom));
        if (!loaded[addr])
            loaded_list.push_back(addr);
        loaded[addr] = 1'b1;
    endtask

    task automatic subtract_at(logic [15:0] addr);
        if (!loaded[addr])
            load_entry(addr);
        send(pss_pkg::CMD_SUB, addr[15:13], addr[12:11], addr[10:8], addr[7:0],
             pick_raw(), 12'($urandom), 16'($urandom));
    endtask

    // A channel read out from its first sample to its last, with random
    // samples between. A rare long run goes past the count limit.
    task automatic channel_readout();
        logic [15:0] base;
        int          mid;
        base = {3'($urandom), 2'($urandom), 3'($urandom), 8'd0};
        mid = ($urandom_range(29) == 0) ? 280 : $urandom_range(10);
        subtract_at(base);
        repeat (mid)
            subtract_at({base[15:8], 8'($urandom_range(254, 1))});
        subtract_at({base[15:8], 8'd255});
    endtask

    // The port is left idle after each write before the task returns.
    task automatic apb_write(logic idx, logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Masks change only once the block has drained and finished any
    // statistics it may still be working on.
    task automatic set_masks(logic [15:0] hitbus, logic [15:0] data);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(pss_pkg::REG_HITBUS_MASK, hitbus);
        apb_write(pss_pkg::REG_DATA_MASK, data);
        hitbus_now = hitbus;
    endtask

    task automatic random_phase(int phase_end);
        int          pick;
        logic [15:0] addr;
        while (items < phase_end)
        begin
            pick = $urandom_range(99);
            addr = loaded_list[$urandom_range(loaded_list.size() - 1)];
            if (pick < 55)
                channel_readout();
            else if (pick < 70)
                load_entry(16'($urandom));
            else if (pick < 85)
                send(pss_pkg::CMD_ADD, addr[15:13], addr[12:11], addr[10:8], addr[7:0],
                     16'($urandom), 12'($urandom), 16'($urandom));
            else if (pick < 95)
                subtract_at(addr);
            else
                send(pss_pkg::CMD_NONE, 3'($urandom), 2'($urandom), 3'($urandom),
                     8'($urandom), 16'($urandom), 12'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        cmd <= pss_pkg::CMD_NONE;
        board <= '0;
        chip <= '0;
        channel <= '0;
        sample_index <= '0;
        raw_word <= '0;
        pedestal_value <= '0;
        subbed_value <= '0;
        out_ready <= 1'b0;
        items = 0;
        gaps_on = 1'b1;
        stall_request = 1'b0;
        quiet_cycles = 0;
        hitbus_now = pss_pkg::HITBUS_MASK_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset masks: the table corners, the forced
        // zero of channel zero's first sample, the most negative sample,
        // channels with no valid samples, restore wrap and the unused command.
        send(pss_pkg::CMD_LOAD, 3'd0, 2'd0, 3'd0, 8'd0, 16'h0, 12'd100, 16'h0);
        send(pss_pkg::CMD_LOAD, 3'd0, 2'd0, 3'd0, 8'd255, 16'h0, 12'd0, 16'h0);
        send(pss_pkg::CMD_LOAD, 3'd7, 2'd3, 3'd7, 8'd0, 16'h0, 12'd0, 16'h0);
        send(pss_pkg::CMD_LOAD, 3'd7, 2'd3, 3'd7, 8'd255, 16'h0, 12'hFFF, 16'h0);
        foreach (loaded[i])
            loaded[i] = 1'b0;
        loaded[16'h0000] = 1'b1;
        loaded[16'h00FF] = 1'b1;
        loaded[16'hFF00] = 1'b1;
        loaded[16'hFFFF] = 1'b1;
        loaded_list = '{16'h0000, 16'h00FF, 16'hFF00, 16'hFFFF};
        send(pss_pkg::CMD_SUB, 3'd0, 2'd0, 3'd0, 8'd0, 16'h0800, 12'd0, 16'h0);
        send(pss_pkg::CMD_SUB, 3'd0, 2'd0, 3'd0, 8'd255, 16'h0FFF, 12'd0, 16'h0);
        send(pss_pkg::CMD_SUB, 3'd7, 2'd3, 3'd7, 8'd0, 16'h0000, 12'd0, 16'h0);
        send(pss_pkg::CMD_SUB, 3'd7, 2'd3, 3'd7, 8'd255, 16'h0000, 12'd0, 16'h0);
        send(pss_pkg::CMD_SUB, 3'd7, 2'd3, 3'd7, 8'd0, 16'h1000, 12'd0, 16'h0);
        send(pss_pkg::CMD_SUB, 3'd7, 2'd3, 3'd7, 8'd255, 16'hF000, 12'd0, 16'h0);
        send(pss_pkg::CMD_ADD, 3'd7, 2'd3, 3'd7, 8'd255, 16'h0, 12'd0, 16'h7FFF);
        send(pss_pkg::CMD_ADD, 3'd7, 2'd3, 3'd7, 8'd255, 16'h0, 12'd0, 16'h8000);
        send(pss_pkg::CMD_ADD, 3'd0, 2'd0, 3'd0, 8'd255, 16'h0, 12'd0, 16'hFFFF);
        send(pss_pkg::CMD_NONE, 3'd7, 2'd3, 3'd7, 8'd255, 16'hFFFF, 12'hFFF, 16'hFFFF);

        random_phase(PHASE_ITEMS);

        // Widest data path: every sample valid and the full word kept. Here
        // the receiver holds off for a long stretch while items keep coming.
        set_masks(16'h0000, 16'hFFFF);
        send(pss_pkg::CMD_SUB, 3'd0, 2'd0, 3'd0, 8'd255, 16'hFFFF, 12'd0, 16'h0);
        stall_request = 1'b1;
        random_phase(2 * PHASE_ITEMS);

        // Everything flagged as hitbus unless the raw word is zero; no gaps.
        set_masks(16'hFFFF, 16'h0000);
        gaps_on = 1'b0;
        random_phase(3 * PHASE_ITEMS);
        gaps_on = 1'b1;

        // The sender pauses until the block has drained completely.
        set_masks(16'h8001, 16'h7FFE);
        random_phase(3 * PHASE_ITEMS + PHASE_ITEMS / 2);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        random_phase(4 * PHASE_ITEMS);

        set_masks(16'($urandom) & 16'hF000, 16'($urandom));
        random_phase(5 * PHASE_ITEMS);

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/pss_pkg.sv
sv/pss_ram.sv
sv/pedestal_subtract_with_channel_stats.sv
tb/pss_checker.sv
tb/testbench.sv
